// ===== hdl/rwws_pkg.sv =====
// Shared constants, types and command/status structs for the wall-follow steering block.
package rwws_pkg;

  localparam int WINDOW_LEN = 8;
  localparam int RANGE_W    = 10;
  localparam int SCORE_W    = 8;
  localparam int CMD_W      = 2;
  localparam int IDX_W      = $clog2(WINDOW_LEN);
  localparam int CFG_IDX_W  = 2;

  localparam int MID  = (WINDOW_LEN + 1) / 2;
  localparam int HALF = WINDOW_LEN / 2;

  localparam logic signed [SCORE_W-1:0] TREND_THR = SCORE_W'(HALF * HALF - (HALF + 1));
  localparam logic signed [SCORE_W-1:0] DIST_THR  = SCORE_W'(WINDOW_LEN - 2);

  localparam logic [IDX_W-1:0] IDX_FIRST_NEW = IDX_W'(MID);
  localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(WINDOW_LEN - 1);

  localparam logic [CMD_W-1:0] CMD_FORWARD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RIGHT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LEFT    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_FOLLOW   = 2'd2;

  localparam logic OP_PRIME  = 1'b0;
  localparam logic OP_FOLLOW = 1'b1;

  typedef struct packed {
    logic             take;        // latch the incoming samples
    logic             prime;       // shift incoming samples now, clear parity
    logic             chk_step;    // test front entry at idx against stop distance
    logic             advance;     // shift the latched samples into the windows
    logic             set_stop;    // result is stop
    logic             set_plain;   // result is plain forward
    logic             start_trend; // clear score, mark trend step
    logic             start_dist;  // clear score, mark distance step
    logic             trend_step;  // add pairwise score of side entry idx
    logic             dist_step;   // add distance score of side entry idx
    logic             decide;      // turn score into a command, toggle parity
    logic             out_load;    // move result into the output register
    logic [IDX_W-1:0] idx;
  } rwws_cmd_t;

  typedef struct packed {
    logic all_below;
    logic follow_en;
    logic parity;
    logic out_free;
  } rwws_status_t;

endpackage

// ===== hdl/range_window_wall_follow_steer.sv =====
// Top level of the wall-follow steering block: stream ports, sequencer and datapath.
//
//  channel  direction  beat contents
//  s_*      in         tuser: operation; tdata: front_range, side_range
//  m_*      out        tuser: was_trend_step; tdata: command, score
//  cfg_*    in         register index and data, no handshake
//
// A prime beat is absorbed in its accept cycle. A follow beat scans the front window one
// entry a cycle, then scores the side window one entry a cycle: the newer entries from
// (WINDOW_LEN+1)/2 on for a trend step, every entry for a distance step. The steps are
// accept, front scan, branch, side scan, decide and output hand-off; a stop result, or a
// plain forward result when wall follow is off, goes from branch straight to hand-off.
// Reset is synchronous and clears the windows, the step parity and the registers to their
// defaults. A result waits in the output register while the next beat is taken; the
// sequencer holds only if a second result is ready before the first has gone.
module range_window_wall_follow_steer
  import rwws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // [9:0] front_range, [19:10] side_range, pad
  input  logic                 s_tuser,   // [0] operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [1:0] command, [9:2] score, pad
  output logic                 m_tuser,   // [0] was_trend_step
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RANGE_W-1:0]   cfg_data
);

  rwws_cmd_t          cmd;
  rwws_status_t       status;
  logic [CMD_W-1:0]   out_command;
  logic [SCORE_W-1:0] out_score;

  // The sequencer decides; the datapath holds all samples, registers and the score.
  rwws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rwws_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_front    (s_tdata[9:0]),
    .in_side     (s_tdata[19:10]),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_command (out_command),
    .out_score   (out_score),
    .out_trend   (m_tuser)
  );

  // Output fields are packed from bit zero; the upper byte remainder is zero fill.
  assign m_tdata = {6'b0, out_score, out_command};

endmodule

// ===== hdl/rwws_ctrl.sv =====
// Sequencer for the wall-follow steering block: walks the window scans and result hand-off.
module rwws_ctrl
  import rwws_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         op,
  output logic         s_tready,
  input  rwws_status_t status,
  output rwws_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_BRANCH = 3'd2;
  localparam logic [2:0] S_TREND  = 3'd3;
  localparam logic [2:0] S_DIST   = 3'd4;
  localparam logic [2:0] S_DEC    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = cnt;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (op == OP_PRIME) begin
            cmd.prime = 1'b1;
          end else begin
            cnt_next   = '0;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.chk_step = 1'b1;
        cnt_next     = cnt + IDX_W'(1);
        if (cnt == IDX_LAST) begin
          state_next = S_BRANCH;
        end
      end
      S_BRANCH: begin
        if (status.all_below) begin
          cmd.set_stop = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.advance = 1'b1;
          if (!status.follow_en) begin
            cmd.set_plain = 1'b1;
            state_next    = S_OUT;
          end else if (!status.parity) begin
            cmd.start_trend = 1'b1;
            cnt_next        = IDX_FIRST_NEW;
            state_next      = S_TREND;
          end else begin
            cmd.start_dist = 1'b1;
            cnt_next       = '0;
            state_next     = S_DIST;
          end
        end
      end
      S_TREND: begin
        cmd.trend_step = 1'b1;
        cnt_next       = cnt + IDX_W'(1);
        if (cnt == IDX_LAST) begin
          state_next = S_DEC;
        end
      end
      S_DIST: begin
        cmd.dist_step = 1'b1;
        cnt_next      = cnt + IDX_W'(1);
        if (cnt == IDX_LAST) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== hdl/rwws_datapath.sv =====
// Range windows, configuration registers, score accumulator and output register.
module rwws_datapath
  import rwws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [RANGE_W-1:0]   in_front,
  input  logic [RANGE_W-1:0]   in_side,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RANGE_W-1:0]   cfg_data,
  input  rwws_cmd_t            cmd,
  output rwws_status_t         status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CMD_W-1:0]     out_command,
  output logic [SCORE_W-1:0]   out_score,
  output logic                 out_trend
);

  logic [RANGE_W-1:0] front_win [WINDOW_LEN];
  logic [RANGE_W-1:0] side_win  [WINDOW_LEN];
  logic               parity;
  logic [RANGE_W-1:0] stop_distance;
  logic [RANGE_W-1:0] wall_distance;
  logic               wall_follow_enable;

  logic [RANGE_W-1:0] front_hold, side_hold;
  logic               all_below;
  logic               trend_mode;
  logic signed [SCORE_W-1:0] score;
  logic [CMD_W-1:0]   res_command;
  logic signed [SCORE_W-1:0] res_score;
  logic               res_trend;

  logic               shift_en;
  logic [RANGE_W-1:0] shift_front, shift_side;
  logic [RANGE_W-1:0] side_sel;
  logic signed [SCORE_W-1:0] trend_sum;
  logic signed [SCORE_W-1:0] dist_term;
  logic signed [SCORE_W-1:0] thr;

  assign shift_en    = cmd.prime || cmd.advance;
  assign shift_front = cmd.prime ? in_front : front_hold;
  assign shift_side  = cmd.prime ? in_side  : side_hold;
  assign side_sel    = side_win[cmd.idx];

  // Pairwise score of one newer entry against every entry of the older half.
  always_comb begin
    trend_sum = '0;
    for (int b = 0; b < MID; b++) begin
      if (side_sel > side_win[b]) begin
        trend_sum = trend_sum + SCORE_W'(1);
      end else if (side_sel < side_win[b]) begin
        trend_sum = trend_sum - SCORE_W'(1);
      end
    end
  end

  always_comb begin
    if (side_sel > wall_distance) begin
      dist_term = SCORE_W'(1);
    end else if (side_sel < wall_distance) begin
      dist_term = -SCORE_W'(1);
    end else begin
      dist_term = '0;
    end
  end

  assign thr = trend_mode ? TREND_THR : DIST_THR;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        front_win[k] <= '0;
        side_win[k]  <= '0;
      end
      parity             <= 1'b0;
      stop_distance      <= RANGE_W'(10);
      wall_distance      <= RANGE_W'(20);
      wall_follow_enable <= 1'b1;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STOP_DISTANCE: stop_distance      <= cfg_data;
          REG_WALL_DISTANCE: wall_distance      <= cfg_data;
          REG_WALL_FOLLOW:   wall_follow_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (shift_en) begin
        for (int k = 0; k < WINDOW_LEN - 1; k++) begin
          front_win[k] <= front_win[k + 1];
          side_win[k]  <= side_win[k + 1];
        end
        front_win[WINDOW_LEN-1] <= shift_front;
        side_win[WINDOW_LEN-1]  <= shift_side;
      end
      if (cmd.prime) begin
        parity <= 1'b0;
      end else if (cmd.decide) begin
        parity <= ~parity;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      front_hold <= in_front;
      side_hold  <= in_side;
      all_below  <= 1'b1;
    end else if (cmd.chk_step && (front_win[cmd.idx] >= stop_distance)) begin
      all_below <= 1'b0;
    end
    if (cmd.start_trend || cmd.start_dist) begin
      score      <= '0;
      trend_mode <= cmd.start_trend;
    end else if (cmd.trend_step) begin
      score <= score + trend_sum;
    end else if (cmd.dist_step) begin
      score <= score + dist_term;
    end
    if (cmd.set_stop) begin
      res_command <= CMD_STOP;
      res_score   <= '0;
      res_trend   <= 1'b0;
    end else if (cmd.set_plain) begin
      res_command <= CMD_FORWARD;
      res_score   <= '0;
      res_trend   <= 1'b0;
    end else if (cmd.decide) begin
      res_score <= score;
      res_trend <= trend_mode;
      if (score < -thr) begin
        res_command <= CMD_RIGHT;
      end else if (score > thr) begin
        res_command <= CMD_LEFT;
      end else begin
        res_command <= CMD_FORWARD;
      end
    end
    if (cmd.out_load) begin
      out_command <= res_command;
      out_score   <= res_score;
      out_trend   <= res_trend;
    end
  end

  assign status.all_below = all_below;
  assign status.follow_en = wall_follow_enable;
  assign status.parity    = parity;
  assign status.out_free  = !out_valid || out_ready;

endmodule
